/* sv/assert_macros.svh */
// assertion macros used by the gpio command parser top level
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SGPIO_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SGPIO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGPIO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sgpio_pkg.sv */
// shared types, constants and status codes of the gpio command parser
// no dependencies
`timescale 1ns / 1ps

package sgpio_pkg;

    // port geometry
    localparam int PORT_COUNT    = 6;
    localparam int PINS_PER_PORT = 8;
    localparam int IMG_BITS      = PORT_COUNT * PINS_PER_PORT;
    localparam int POS_W         = $clog2(IMG_BITS);
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 6;
    localparam int STATUS_W      = 3;

    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [IMG_BITS-1:0] image_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [STATUS_W-1:0] status_t;

    // status codes
    localparam status_t ST_WROTE     = 3'd0;
    localparam status_t ST_READ      = 3'd1;
    localparam status_t ST_TOO_SHORT = 3'd2;
    localparam status_t ST_BAD_PORT  = 3'd3;
    localparam status_t ST_BAD_PIN   = 3'd4;
    localparam status_t ST_BAD_VALUE = 3'd5;
    localparam status_t ST_BAD_CMD   = 3'd6;

    // characters of the command syntax
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_ZERO    = 8'h30;
    localparam char_t CH_ONE     = 8'h31;
    localparam char_t CH_QUERY   = 8'h3F;
    localparam char_t CH_EQUAL   = 8'h3D;

    // length thresholds
    localparam len_t MIN_LEN   = 6'd3;
    localparam len_t WRITE_LEN = 6'd4;

    // one command as held in the input register
    typedef struct packed {
        char_t  port_char;
        char_t  pin_char;
        char_t  op_char;
        char_t  value_char;
        len_t   command_length;
        image_t pad_levels;
    } cmd_t;

    // register file update request
    typedef struct packed {
        logic rd_clr;
        logic wr;
        logic value;
        pos_t pos;
    } upd_t;

    // decoder result
    typedef struct packed {
        status_t status;
        logic    level;
        char_t   echo;
        upd_t    upd;
    } dec_t;

endpackage

/* sv/sgpio_cmd_if.sv */
// command channel: valid/ready handshake with the command characters and pad levels
// depends on sgpio_pkg
`timescale 1ns / 1ps

interface sgpio_cmd_if;
    import sgpio_pkg::*;

    logic   valid;
    logic   ready;
    char_t  port_char;
    char_t  pin_char;
    char_t  op_char;
    char_t  value_char;
    len_t   command_length;
    image_t pad_levels;

    modport source (
        output valid, port_char, pin_char, op_char, value_char, command_length, pad_levels,
        input  ready
    );

    modport sink (
        input  valid, port_char, pin_char, op_char, value_char, command_length, pad_levels,
        output ready
    );
endinterface

/* sv/sgpio_rsp_if.sv */
// response channel: valid/ready handshake with status, echo and register images
// depends on sgpio_pkg
`timescale 1ns / 1ps

interface sgpio_rsp_if;
    import sgpio_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    logic    read_level;
    char_t   offending_char;
    image_t  direction_image;
    image_t  latch_image;

    modport source (
        output valid, status, read_level, offending_char, direction_image, latch_image,
        input  ready
    );

    modport sink (
        input  valid, status, read_level, offending_char, direction_image, latch_image,
        output ready
    );
endinterface

/* sv/serial_gpio_command_parser.sv */
// Serial GPIO command parser top level: input register, decoder, register file,
// result register. A command passes through the input register, then the result register.
// Throughput: one command per cycle while the result register is free or rsp.ready is
// high; the direction/latch register file is read and updated between the input and result registers.
// Reset: both pipeline stages empty, all direction and latch bits zero (pins inputs).
// Depends on sgpio_pkg, sgpio_cmd_if, sgpio_rsp_if, sgpio_decode, sgpio_regfile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_gpio_command_parser (
    input  logic         clk,
    input  logic         rst_n,
    sgpio_cmd_if.sink    cmd,
    sgpio_rsp_if.source  rsp
);
    import sgpio_pkg::*;

    logic    s1_valid_reg;
    cmd_t    s1_cmd_reg;
    logic    out_valid_reg;
    status_t out_status_reg;
    logic    out_level_reg;
    char_t   out_echo_reg;
    image_t  out_dir_reg;
    image_t  out_latch_reg;

    logic    s1_move;
    logic    in_take;
    dec_t    dec;
    image_t  dir_image;
    image_t  latch_image;
    image_t  dir_next;
    image_t  latch_next;

    // pipeline flow control
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_move;
    assign in_take   = cmd.valid && cmd.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg.port_char      <= cmd.port_char;
            s1_cmd_reg.pin_char       <= cmd.pin_char;
            s1_cmd_reg.op_char        <= cmd.op_char;
            s1_cmd_reg.value_char     <= cmd.value_char;
            s1_cmd_reg.command_length <= cmd.command_length;
            s1_cmd_reg.pad_levels     <= cmd.pad_levels;
        end
    end

    // decode and register update
    sgpio_decode u_decode (
        .cmd (s1_cmd_reg),
        .dec (dec)
    );

    sgpio_regfile u_regfile (
        .clk         (clk),
        .rst_n       (rst_n),
        .apply       (s1_move),
        .upd         (dec.upd),
        .dir_image   (dir_image),
        .latch_image (latch_image),
        .dir_next    (dir_next),
        .latch_next  (latch_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_status_reg <= dec.status;
            out_level_reg  <= dec.level;
            out_echo_reg   <= dec.echo;
            out_dir_reg    <= dir_next;
            out_latch_reg  <= latch_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.read_level      = out_level_reg;
    assign rsp.offending_char  = out_echo_reg;
    assign rsp.direction_image = out_dir_reg;
    assign rsp.latch_image     = out_latch_reg;

    // checks
    `SGPIO_ASSERT_IMPL(a_ready_when_out_free, !out_valid_reg, cmd.ready, "input stalled with free result register")
    `SGPIO_ASSERT_IMPL(a_latch_only_on_write, s1_move && (dec.status != ST_WROTE), latch_next == latch_image, "latch changed without a write")
    `SGPIO_ASSERT_IMPL(a_dir_only_on_access, s1_move && (dec.status != ST_WROTE) && (dec.status != ST_READ), dir_next == dir_image, "direction changed on an error")
    `SGPIO_ASSERT_NEXT(a_images_match_state, s1_move, (out_dir_reg == dir_image) && (out_latch_reg == latch_image), "result images differ from register state")
    `SGPIO_ASSERT_IMPL(a_level_only_on_read, out_valid_reg && out_level_reg, out_status_reg == ST_READ, "pad level reported outside a read")
endmodule

/* sv/sgpio_decode.sv */
// command decoder: checks the characters and builds status, read level, echo and register update
// depends on sgpio_pkg
`timescale 1ns / 1ps

module sgpio_decode (
    input  sgpio_pkg::cmd_t cmd,
    output sgpio_pkg::dec_t dec
);
    import sgpio_pkg::*;

    localparam char_t UPPER_END = CH_UPPER_A + CHAR_W'(PORT_COUNT);
    localparam char_t LOWER_END = CH_LOWER_A + CHAR_W'(PORT_COUNT);
    localparam char_t PIN_END   = CH_ZERO + CHAR_W'(PINS_PER_PORT);

    logic  upper_hit;
    logic  lower_hit;
    logic  port_ok;
    logic  pin_ok;
    char_t port_off;
    char_t pin_off;
    pos_t  pos;

    // port letter and pin digit
    assign upper_hit = (cmd.port_char >= CH_UPPER_A) && (cmd.port_char < UPPER_END);
    assign lower_hit = (cmd.port_char >= CH_LOWER_A) && (cmd.port_char < LOWER_END);
    assign port_ok   = upper_hit || lower_hit;
    assign port_off  = upper_hit ? (cmd.port_char - CH_UPPER_A) : (cmd.port_char - CH_LOWER_A);
    assign pin_ok    = (cmd.pin_char >= CH_ZERO) && (cmd.pin_char < PIN_END);
    assign pin_off   = cmd.pin_char - CH_ZERO;

    // packed bit position of the addressed pin
    assign pos = POS_W'(port_off) * POS_W'(PINS_PER_PORT) + POS_W'(pin_off);

    // checks in priority order
    always_comb
    begin
        dec          = '0;
        dec.upd.pos  = pos;
        dec.upd.value = (cmd.value_char == CH_ONE);
        if (cmd.command_length < MIN_LEN)
        begin
            dec.status = ST_TOO_SHORT;
        end
        else if (!port_ok)
        begin
            dec.status = ST_BAD_PORT;
            dec.echo   = cmd.port_char;
        end
        else if (!pin_ok)
        begin
            dec.status = ST_BAD_PIN;
            dec.echo   = cmd.pin_char;
        end
        else if (cmd.op_char == CH_QUERY)
        begin
            dec.status     = ST_READ;
            dec.level      = cmd.pad_levels[pos];
            dec.upd.rd_clr = 1'b1;
        end
        else if ((cmd.command_length >= WRITE_LEN) && (cmd.op_char == CH_EQUAL))
        begin
            if ((cmd.value_char == CH_ZERO) || (cmd.value_char == CH_ONE))
            begin
                dec.status = ST_WROTE;
                dec.upd.wr = 1'b1;
            end
            else
            begin
                dec.status = ST_BAD_VALUE;
                dec.echo   = cmd.value_char;
            end
        end
        else
        begin
            dec.status = ST_BAD_CMD;
            dec.echo   = cmd.port_char;
        end
    end
endmodule

/* sv/sgpio_regfile.sv */
// direction and output latch registers of all ports, read-modify-write via combinational next images
// depends on sgpio_pkg
`timescale 1ns / 1ps

module sgpio_regfile (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             apply,
    input  sgpio_pkg::upd_t  upd,
    output sgpio_pkg::image_t dir_image,
    output sgpio_pkg::image_t latch_image,
    output sgpio_pkg::image_t dir_next,
    output sgpio_pkg::image_t latch_next
);
    import sgpio_pkg::*;

    image_t dir_reg;
    image_t latch_reg;
    image_t bit_mask;

    assign bit_mask = IMG_BITS'(1) << upd.pos;

    // next images after the pending update
    always_comb
    begin
        dir_next   = dir_reg;
        latch_next = latch_reg;
        if (apply && upd.rd_clr)
        begin
            dir_next = dir_reg & ~bit_mask;
        end
        else if (apply && upd.wr)
        begin
            dir_next   = dir_reg | bit_mask;
            latch_next = upd.value ? (latch_reg | bit_mask) : (latch_reg & ~bit_mask);
        end
    end

    // state registers, all pins inputs after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            latch_reg <= '0;
        end
        else
        begin
            dir_reg   <= dir_next;
            latch_reg <= latch_next;
        end
    end

    assign dir_image   = dir_reg;
    assign latch_image = latch_reg;
endmodule
